### rtl/core/assert_macros.svh
// assertion macros shared by the rtl, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every edge outside reset
`define AST_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// consequent must hold at the next edge after the antecedent
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define AST_ALWAYS(lbl, clk, rstn, expr, msg)
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/core/ngfs_pkg.sv
// shared types, codes and helpers of the n-gram fitness scorer
package ngfs_pkg;

  localparam int SUM_W    = 18;
  localparam int SCORE_W  = 17;
  localparam int LETTER_W = 5;
  localparam int INDEX_W  = 24;
  localparam int VALUE_W  = 8;
  localparam int NGRAMS   = 4;

  localparam logic [2:0] SEEN_MAX = 3'd4;

  typedef enum logic {
    CMD_SCORE = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    TBL_PAIR  = 2'd0,
    TBL_TRIPLE = 2'd1,
    TBL_QUAD  = 2'd2,
    TBL_QUINT = 2'd3
  } tbl_sel_t;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [NGRAMS-1:0][SUM_W-1:0] sum_vec_t;

  // control of the accumulate stage
  typedef struct packed {
    logic              step;
    logic              last;
    logic [NGRAMS-1:0] en;
  } acc_ctl_t;

  function automatic sum_t sat_add(sum_t a, sum_t b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

endpackage

### rtl/core/ngfs_ram.sv
// generic single-port-write, single-port-read ram with registered read
module ngfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 676
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ngfs_accum.sv
// saturating n-gram accumulators and the captured final sums
module ngfs_accum import ngfs_pkg::*; #(
  parameter int WW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  acc_ctl_t                   ctl,
  input  logic [NGRAMS-1:0][WW-1:0]  weight,
  output sum_vec_t                   fin
);

  sum_vec_t run_r;
  sum_vec_t run_nxt;
  sum_vec_t fin_r;

  always_comb begin
    for (int k = 0; k < NGRAMS; k++) begin
      run_nxt[k] = ctl.en[k] ? sat_add(run_r[k], SUM_W'(weight[k])) : run_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (ctl.step) begin
      run_r <= ctl.last ? '0 : run_nxt;
    end
  end

  // final sums of a finished text
  always_ff @(posedge clk) begin
    if (ctl.step && ctl.last) begin
      fin_r <= run_nxt;
    end
  end

  assign fin = fin_r;

endmodule

### rtl/core/ngram_fitness_scorer.sv
// top level of the n-gram log-frequency fitness scorer
//
// scores a plaintext streamed one letter per word (in_tuser = 0) against four
// weight tables of 2-, 3-, 4- and 5-letter n-grams, which are loaded one entry
// per word (in_tuser = 1); every entry must be written before it is scored.
// each table sits in its own ram with one registered read port, and the block
// keeps prefix indices of the last one to four letters so that every window
// address is one multiply-by-alphabet plus add. one word is taken every cycle
// while in_tready is high: a letter issues its four table reads at its accept
// edge, adds the weights into saturating 18-bit sums in the accumulate stage,
// and the word with tlast set yields score = (pair>>5)+(triple>>4)+(quad>>3)+
// (quint>>2) via the final-sum stage and the output register. a finished score
// waits in the output register and one more waits in the final-sum stage; the
// input stops accepting only when both are held by out_tready and a third last
// letter sits in the accumulate stage. letters at or above the alphabet size
// count as the last alphabet letter, and writes past a table's depth are dropped.
module ngram_fitness_scorer import ngfs_pkg::*; #(
  parameter int ALPHABET_SIZE = 26,
  parameter int WEIGHT_WIDTH  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // letter[4:0], table_select[6:5], table_index[30:7], table_value[38:31], zero pad
  input  logic [39:0] in_tdata,
  // command[0]
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // score[16:0], zero pad
  output logic [23:0] out_tdata
);

`include "assert_macros.svh"

  localparam int AS  = ALPHABET_SIZE;
  localparam int WW  = (WEIGHT_WIDTH < VALUE_W) ? WEIGHT_WIDTH : VALUE_W;
  localparam int D2  = AS * AS;
  localparam int D3  = D2 * AS;
  localparam int D4  = D3 * AS;
  localparam int D5  = D4 * AS;
  localparam int LW  = $clog2(AS);
  localparam int A2W = $clog2(D2);
  localparam int A3W = $clog2(D3);
  localparam int A4W = $clog2(D4);
  localparam int A5W = $clog2(D5);

  // field unpacking
  logic [LETTER_W-1:0] letter;
  tbl_sel_t            tbl_sel;
  logic [INDEX_W-1:0]  tbl_index;
  logic [VALUE_W-1:0]  tbl_value;
  cmd_t                cmd;

  assign letter    = in_tdata[4:0];
  assign tbl_sel   = tbl_sel_t'(in_tdata[6:5]);
  assign tbl_index = in_tdata[30:7];
  assign tbl_value = in_tdata[38:31];
  assign cmd       = cmd_t'(in_tuser);

  logic in_acc;
  logic acc_score;
  logic acc_write;

  assign in_acc    = in_tvalid && in_tready;
  assign acc_score = in_acc && (cmd == CMD_SCORE);
  assign acc_write = in_acc && (cmd == CMD_WRITE);

  // letter clamped into the alphabet
  logic [LW-1:0] x;
  assign x = ({1'b0, letter} >= (LETTER_W + 1)'(AS)) ? LW'(AS - 1) : LW'(letter);

  // prefix indices of the last one, two, three and four letters
  logic [LW-1:0]  p1_r;
  logic [A2W-1:0] p2_r;
  logic [A3W-1:0] p3_r;
  logic [A4W-1:0] p4_r;
  logic [2:0]     seen_r;

  // window indices ending at the current letter
  logic [A2W-1:0] i2;
  logic [A3W-1:0] i3;
  logic [A4W-1:0] i4;
  logic [A5W-1:0] i5;

  assign i2 = A2W'(32'(p1_r) * 32'(AS) + 32'(x));
  assign i3 = A3W'(32'(p2_r) * 32'(AS) + 32'(x));
  assign i4 = A4W'(32'(p3_r) * 32'(AS) + 32'(x));
  assign i5 = A5W'(32'(p4_r) * 32'(AS) + 32'(x));

  logic [NGRAMS-1:0] win_en;
  assign win_en = {seen_r >= 3'd4, seen_r >= 3'd3, seen_r >= 3'd2, seen_r >= 3'd1};

  // table write decode, out-of-range indices dropped
  logic [NGRAMS-1:0] we;
  logic [WW-1:0]     wdata;

  assign wdata = tbl_value[WW-1:0];

  always_comb begin
    we = '0;
    unique case (tbl_sel)
      TBL_PAIR:   we[0] = acc_write && (32'(tbl_index) < 32'(D2));
      TBL_TRIPLE: we[1] = acc_write && (32'(tbl_index) < 32'(D3));
      TBL_QUAD:   we[2] = acc_write && (32'(tbl_index) < 32'(D4));
      TBL_QUINT:  we[3] = acc_write && (32'(tbl_index) < 32'(D5));
      default:    we    = '0;
    endcase
  end

  // weight memories, read at the accept edge of each letter
  logic [NGRAMS-1:0][WW-1:0] weight;

  ngfs_ram #(.WIDTH(WW), .DEPTH(D2)) u_pair_ram (
    .clk  (clk),
    .we   (we[0]),
    .waddr(A2W'(tbl_index)),
    .wdata(wdata),
    .re   (acc_score),
    .raddr(i2),
    .rdata(weight[0])
  );

  ngfs_ram #(.WIDTH(WW), .DEPTH(D3)) u_triple_ram (
    .clk  (clk),
    .we   (we[1]),
    .waddr(A3W'(tbl_index)),
    .wdata(wdata),
    .re   (acc_score),
    .raddr(i3),
    .rdata(weight[1])
  );

  ngfs_ram #(.WIDTH(WW), .DEPTH(D4)) u_quad_ram (
    .clk  (clk),
    .we   (we[2]),
    .waddr(A4W'(tbl_index)),
    .wdata(wdata),
    .re   (acc_score),
    .raddr(i4),
    .rdata(weight[2])
  );

  ngfs_ram #(.WIDTH(WW), .DEPTH(D5)) u_quint_ram (
    .clk  (clk),
    .we   (we[3]),
    .waddr(A5W'(tbl_index)),
    .wdata(wdata),
    .re   (acc_score),
    .raddr(i5),
    .rdata(weight[3])
  );

  // stage flow: accumulate stage, final-sum stage, output register
  logic              s1_v_r;
  logic              s1_last_r;
  logic [NGRAMS-1:0] s1_en_r;
  logic              fin_v_r;
  logic              out_valid_r;
  logic [SCORE_W-1:0] out_score_r;

  logic out_free;
  logic fin_free;
  logic s1_stall;
  logic s1_step;

  assign out_free = !out_valid_r || out_tready;
  assign fin_free = !fin_v_r || out_free;
  // a finishing text must find room for its final sums
  assign s1_stall = s1_v_r && s1_last_r && !fin_free;
  assign s1_step  = s1_v_r && !s1_stall;
  assign in_tready = !s1_stall;

  // running text state, cleared by the last letter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r   <= '0;
      p2_r   <= '0;
      p3_r   <= '0;
      p4_r   <= '0;
      seen_r <= '0;
    end else if (acc_score) begin
      if (in_tlast) begin
        p1_r   <= '0;
        p2_r   <= '0;
        p3_r   <= '0;
        p4_r   <= '0;
        seen_r <= '0;
      end else begin
        p1_r   <= x;
        p2_r   <= i2;
        p3_r   <= i3;
        p4_r   <= i4;
        if (seen_r < SEEN_MAX) begin
          seen_r <= seen_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!s1_stall) begin
      s1_v_r <= acc_score;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_score) begin
      s1_last_r <= in_tlast;
      s1_en_r   <= win_en;
    end
  end

  acc_ctl_t acc_ctl;
  sum_vec_t fin;

  assign acc_ctl.step = s1_step;
  assign acc_ctl.last = s1_last_r;
  assign acc_ctl.en   = s1_en_r;

  ngfs_accum #(.WW(WW)) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .weight(weight),
    .fin   (fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (s1_step && s1_last_r) begin
      fin_v_r <= 1'b1;
    end else if (out_free) begin
      fin_v_r <= 1'b0;
    end
  end

  // weighted combination of the four window sums
  logic [SCORE_W-1:0] score_nxt;
  assign score_nxt = SCORE_W'(fin[0] >> 5) + SCORE_W'(fin[1] >> 4)
                   + SCORE_W'(fin[2] >> 3) + SCORE_W'(fin[3] >> 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_v_r) begin
      out_score_r <= score_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(24 - SCORE_W)'(0), out_score_r};

  // checks
  `AST_ALWAYS(a_seen_range, clk, rst_n, seen_r <= SEEN_MAX, "letter count beyond four")
  `AST_NEXT(a_last_clears, clk, rst_n, acc_score && in_tlast, seen_r == 3'd0, "text state not cleared")
  `AST_NEXT(a_write_no_step, clk, rst_n, acc_write, !s1_v_r, "table write entered accumulate stage")
  `AST_NEXT(a_fin_held, clk, rst_n, fin_v_r && !out_free, fin_v_r, "final sums lost under backpressure")

endmodule

### sim/testbench.sv
// self-checking testbench of the n-gram fitness scorer: loads weights, scores texts, checks each score
module testbench;
  import ngfs_pkg::*;

  localparam int          ALPHA        = 26;
  localparam logic [4:0]  LAST_LETTER  = 5'd25;
  localparam int unsigned NGRAM_DEPTH [4] = '{676, 17576, 456976, 11881376};
  localparam int          DRAIN_CYCLES = 20;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PHASE_WORDS  = 120;
  localparam int          SAT_LETTERS  = 1040;

  // one input word, unpacked
  typedef struct {
    cmd_t         cmd;
    logic [4:0]   letter;
    logic         last;
    tbl_sel_t     sel;
    logic [23:0]  idx;
    logic [7:0]   weight;
  } word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  ngram_fitness_scorer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // predictor state: sparse weight tables and the running text
  logic [7:0]         pair_w   [int unsigned];
  logic [7:0]         triple_w [int unsigned];
  logic [7:0]         quad_w   [int unsigned];
  logic [7:0]         quint_w  [int unsigned];
  logic [4:0]         recent [4];      // oldest letter at 0
  int unsigned        seen_cnt;
  logic [SUM_W-1:0]   ngram_sum [4];
  logic [SCORE_W-1:0] pending_scores [$];

  // letters that random texts draw from; every n-gram over them is loaded
  logic [4:0]  text_letters [3];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;
  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned letters_sent;
  int unsigned writes_sent;
  int unsigned scores_checked;

  function automatic void clear_text();
    for (int n = 0; n < 4; n++) begin
      recent[n]    = '0;
      ngram_sum[n] = '0;
    end
    seen_cnt = 0;
  endfunction

  function automatic void store_weight(tbl_sel_t sel, int unsigned idx, logic [7:0] w);
    if (idx >= NGRAM_DEPTH[int'(sel)]) return;   // out-of-range write is dropped
    case (sel)
      TBL_PAIR:   pair_w[idx]   = w;
      TBL_TRIPLE: triple_w[idx] = w;
      TBL_QUAD:   quad_w[idx]   = w;
      TBL_QUINT:  quint_w[idx]  = w;
    endcase
  endfunction

  function automatic logic [7:0] stored_weight(int n, int unsigned idx);
    case (n)
      0: if (pair_w.exists(idx))   return pair_w[idx];
      1: if (triple_w.exists(idx)) return triple_w[idx];
      2: if (quad_w.exists(idx))   return quad_w[idx];
      3: if (quint_w.exists(idx))  return quint_w[idx];
      default: ;
    endcase
    $display("%0t: stimulus read unwritten %0d-letter entry %0d", $time, n + 2, idx);
    fail_count++;
    return '0;
  endfunction

  // adds every window that ends at this letter, emits a score on the last one
  function automatic void score_letter(logic [4:0] code, logic last);
    int unsigned        idx [4];
    logic [4:0]         x;
    logic [SUM_W:0]     wide;
    logic [SCORE_W-1:0] score;
    x = (code >= ALPHA) ? LAST_LETTER : code;
    idx[0] = recent[3] * ALPHA + x;
    idx[1] = recent[2] * NGRAM_DEPTH[0] + idx[0];
    idx[2] = recent[1] * NGRAM_DEPTH[1] + idx[1];
    idx[3] = recent[0] * NGRAM_DEPTH[2] + idx[2];
    for (int n = 0; n < 4; n++) begin
      if (seen_cnt > n) begin
        wide = {1'b0, ngram_sum[n]} + stored_weight(n, idx[n]);
        ngram_sum[n] = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
      end
    end
    recent[0] = recent[1];
    recent[1] = recent[2];
    recent[2] = recent[3];
    recent[3] = x;
    if (seen_cnt < 4) seen_cnt++;
    if (last) begin
      score = SCORE_W'((ngram_sum[0] >> 5) + (ngram_sum[1] >> 4) + (ngram_sum[2] >> 3)
                       + (ngram_sum[3] >> 2));
      pending_scores.push_back(score);
      clear_text();
    end
  endfunction

  function automatic word_t letter_word(logic [4:0] letter, logic last);
    word_t w;
    w.cmd    = CMD_SCORE;
    w.letter = letter;
    w.last   = last;
    // table fields carry junk on a letter word
    w.sel    = tbl_sel_t'($urandom_range(3));
    w.idx    = 24'($urandom_range(24'hFFFFFF));
    w.weight = 8'($urandom_range(255));
    return w;
  endfunction

  function automatic word_t table_word(tbl_sel_t sel, int unsigned idx, logic [7:0] weight);
    word_t w;
    w.cmd    = CMD_WRITE;
    w.letter = 5'($urandom_range(31));   // ignored on a write
    w.last   = 1'($urandom_range(1));
    w.sel    = sel;
    w.idx    = 24'(idx);
    w.weight = weight;
    return w;
  endfunction

  function automatic logic [7:0] rand_weight();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // letter from the loaded set; the last letter sometimes comes as a code above z
  function automatic logic [4:0] pick_letter();
    logic [4:0] l;
    l = text_letters[$urandom_range(2)];
    if (l == LAST_LETTER && $urandom_range(3) == 0) l = 5'($urandom_range(31, ALPHA));
    return l;
  endfunction

  function automatic int unsigned set_index(int n_letters);
    int unsigned idx;
    idx = 0;
    for (int k = 0; k < n_letters; k++) idx = idx * ALPHA + text_letters[$urandom_range(2)];
    return idx;
  endfunction

  // write that lands mid-text: a live entry, a stray entry, or one past the depth
  function automatic word_t noise_write();
    tbl_sel_t sel;
    sel = tbl_sel_t'($urandom_range(3));
    case ($urandom_range(9))
      0, 1, 2, 3: return table_word(sel, set_index(int'(sel) + 2), rand_weight());
      4, 5, 6:    return table_word(sel, $urandom_range(NGRAM_DEPTH[int'(sel)] - 1),
                                    rand_weight());
      default:    return table_word(sel, $urandom_range(24'hFFFFFF, NGRAM_DEPTH[int'(sel)]),
                                    rand_weight());
    endcase
  endfunction

  // drive one word from a falling edge, hold it until accepted, then predict
  task automatic send_word(input word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, w.weight, w.idx, w.sel, w.letter};
    in_tuser  <= w.cmd;
    in_tlast  <= w.last;
    do @(posedge clk); while (!in_tready);
    if (w.cmd == CMD_WRITE) begin
      store_weight(w.sel, w.idx, w.weight);
      writes_sent++;
    end else begin
      score_letter(w.letter, w.last);
      letters_sent++;
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input int unsigned len, input bit with_noise);
    for (int unsigned i = 0; i < len; i++) begin
      if (with_noise && $urandom_range(99) < 12) send_word(noise_write());
      send_word(letter_word(pick_letter(), i == len - 1));
    end
  endtask

  // writes every n-gram over {a, b, z} so texts over that set never hit an empty entry
  task automatic load_letter_set(input logic [4:0] a, input logic [4:0] b);
    int unsigned combos;
    int unsigned code;
    int unsigned idx;
    text_letters[0] = a;
    text_letters[1] = b;
    text_letters[2] = LAST_LETTER;
    for (int n = 2; n <= 5; n++) begin
      combos = 3 ** n;
      for (int unsigned c = 0; c < combos; c++) begin
        idx  = 0;
        code = c;
        for (int k = 0; k < n; k++) begin
          idx  = idx * ALPHA + text_letters[code % 3];
          code = code / 3;
        end
        send_word(table_word(tbl_sel_t'(n - 2), idx, rand_weight()));
      end
    end
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // first entry of the pair and triple tables, last entry of the quad and quint tables, at both weight extremes
  task automatic test_table_extremes();
    send_word(table_word(TBL_PAIR,   0, 8'd255));
    send_word(table_word(TBL_TRIPLE, 0, 8'd0));
    send_word(table_word(TBL_QUAD,   NGRAM_DEPTH[2] - 1, 8'd255));
    send_word(table_word(TBL_QUINT,  NGRAM_DEPTH[3] - 1, 8'd0));
  endtask

  // one-, two-, five- and six-letter texts, including every code above z
  task automatic test_short_texts();
    send_word(letter_word(5'd0, 1'b1));   // single letter scores zero
    send_word(letter_word(5'd0, 1'b0));
    send_word(letter_word(5'd0, 1'b1));
    send_word(letter_word(5'd25, 1'b0));
    send_word(letter_word(5'd13, 1'b0));
    send_word(letter_word(5'd0,  1'b0));
    send_word(letter_word(5'd13, 1'b0));
    send_word(letter_word(5'd25, 1'b1));
    for (int c = ALPHA; c <= 31; c++) send_word(letter_word(5'(c), c == 31));
  endtask

  // writes past each depth are dropped; a write inside a text keeps its history
  task automatic test_write_rules();
    send_word(table_word(TBL_PAIR,   NGRAM_DEPTH[0], 8'd255));
    send_word(table_word(TBL_TRIPLE, NGRAM_DEPTH[1], 8'd255));
    send_word(table_word(TBL_QUAD,   NGRAM_DEPTH[2], 8'd255));
    send_word(table_word(TBL_QUINT,  NGRAM_DEPTH[3], 8'd255));
    send_word(table_word(TBL_PAIR,   24'hFFFFFF,     8'd255));
    send_word(letter_word(5'd0, 1'b0));
    send_word(letter_word(5'd13, 1'b0));
    send_word(table_word(TBL_PAIR, 13 * ALPHA + 25, 8'd200));
    send_word(table_word(TBL_TRIPLE, 13 * ALPHA + 25, 8'd131));
    send_word(letter_word(5'd25, 1'b1));
  endtask

  // a text well past the maximum length with top weights drives every sum to its ceiling
  task automatic test_saturation();
    int unsigned idx;
    idx = 0;
    for (int n = 0; n < 4; n++) begin
      idx = (n == 0) ? 25 * ALPHA + 25 : idx * ALPHA + 25;
      send_word(table_word(tbl_sel_t'(n), idx, 8'd255));
    end
    for (int i = 0; i < SAT_LETTERS; i++)
      send_word(letter_word(5'(($urandom_range(3) == 0) ? $urandom_range(31, ALPHA) : 25),
                            i == SAT_LETTERS - 1));
  endtask

  // mostly short texts, a few long ones, writes sprinkled in
  task automatic test_random_texts(input int unsigned count);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < count)
      send_text(($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10),
                1'b1);
  endtask

  // receiver stalls for a long stretch while short texts keep coming
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (40) send_text($urandom_range(1, 2), 1'b0);
  endtask

  // receiver: random ready, or a counted hold when one is requested
  initial begin : receiver
    int unsigned hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // every accepted score against the oldest expected one
  always @(posedge clk) begin : score_check
    logic [SCORE_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected score, expected none, actual %0d", $time,
                 out_tdata[SCORE_W-1:0]);
        fail_count++;
      end else begin
        want = pending_scores.pop_front();
        if (out_tdata[SCORE_W-1:0] !== want) begin
          $display("%0t: score mismatch, expected %0d, actual %0d", $time, want,
                   out_tdata[SCORE_W-1:0]);
          fail_count++;
        end
        scores_checked++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    in_tlast       = 1'b0;
    hold_request   = 0;
    fail_count     = 0;
    words_sent     = 0;
    letters_sent   = 0;
    writes_sent    = 0;
    scores_checked = 0;
    clear_text();
    set_idling(18, 70);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_letter_set(5'd0, 5'd13);
    test_table_extremes();
    test_short_texts();
    test_write_rules();
    test_saturation();
    test_random_texts(PHASE_WORDS);

    set_idling(70, 18);
    test_random_texts(PHASE_WORDS);

    set_idling(0, 0);
    test_random_texts(PHASE_WORDS);
    test_backpressure();

    in_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d words sent, %0d letters, %0d table writes, %0d scores checked",
             words_sent, letters_sent, writes_sent, scores_checked);
    $display("run: short texts, codes above z, dropped writes, saturation, long output stall");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ngfs_pkg.sv
rtl/core/ngfs_ram.sv
rtl/core/ngfs_accum.sv
rtl/core/ngram_fitness_scorer.sv
sim/testbench.sv
